### rtl/core/piecewise_line_time_interpolator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line/time interpolator
// Shared property forms, reset-qualified on the active-low synchronous reset.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINE_TIME_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINE_TIME_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication.
`define PLTI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define PLTI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/plti_pkg.sv
// ----------------------------------------------------------------------------
// Line/time interpolator package
// Table sizes, field widths, operation and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package plti_pkg;
    localparam int TABLE_DEPTH    = 1024;
    localparam int ADDR_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W          = ADDR_W + 1;
    localparam int LINE_FRAC_BITS = 8;
    localparam int BLINE_W        = 20;
    localparam int TIME_W         = 40;
    localparam int LV_W           = 28;
    localparam int LOUT_W         = 29;
    localparam int FL_W           = 24;
    localparam int SMP_W          = 28;
    localparam int PROD_W         = 69;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_LOAD  = 2'd0;
    localparam t_op OP_CLEAR = 2'd1;
    localparam t_op OP_T2L   = 2'd2;
    localparam t_op OP_L2T   = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_ORDER = 2'd2;
    localparam t_status ST_SHORT = 2'd3;
endpackage

### rtl/core/plti_muldiv.sv
// ----------------------------------------------------------------------------
// Serial multiply-divide unit
// Computes round(a * b / d), ties up, by shift-add then restoring division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module plti_muldiv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [plti_pkg::TIME_W-1:0] i_a,
    input  logic [plti_pkg::TIME_W-1:0] i_b,
    input  logic [plti_pkg::TIME_W-1:0] i_d,
    output logic                        o_done,
    output logic [plti_pkg::PROD_W-1:0] o_quot
);
    import plti_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_HALF = 2'd2;
    localparam logic [1:0] PH_DIV  = 2'd3;

    logic [1:0]          r_ph;
    logic [6:0]          r_cnt;
    logic [79:0]         r_mcand;
    logic [TIME_W-1:0]   r_mplier;
    logic [79:0]         r_acc;
    logic [TIME_W-1:0]   r_d;
    logic [PROD_W-1:0]   r_dq;
    logic [TIME_W:0]     r_rem;
    logic                r_done;
    logic [TIME_W:0]     n_rem;

    // Partial remainder with the next dividend bit shifted in.
    assign n_rem = {r_rem[TIME_W-1:0], r_dq[PROD_W-1]};

    // Sequencer: one multiplier bit or one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_ph)
                PH_IDLE: begin
                    if (i_start) begin
                        r_mcand  <= {40'd0, i_a};
                        r_mplier <= i_b;
                        r_d      <= i_d;
                        r_acc    <= '0;
                        r_cnt    <= 7'(TIME_W);
                        r_ph     <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= {r_mcand[78:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[TIME_W-1:1]};
                    r_cnt    <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_ph <= PH_HALF;
                    end
                end
                PH_HALF: begin
                    r_dq  <= r_acc[PROD_W-1:0] + PROD_W'({1'b0, r_d[TIME_W-1:1]});
                    r_rem <= '0;
                    r_cnt <= 7'(PROD_W);
                    r_ph  <= PH_DIV;
                end
                PH_DIV: begin
                    if (n_rem >= {1'b0, r_d}) begin
                        r_rem <= n_rem - {1'b0, r_d};
                        r_dq  <= {r_dq[PROD_W-2:0], 1'b1};
                    end else begin
                        r_rem <= n_rem;
                        r_dq  <= {r_dq[PROD_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_done <= 1'b1;
                        r_ph   <= PH_IDLE;
                    end
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dq;
endmodule

### rtl/core/piecewise_line_time_interpolator.sv
// Load, clear and short-table requests strobe from idle or after the load check; a query
// out of span strobes after reading the first and last entries; any other query runs a
// binary search on the single read port, a read and a compare per step, then the shared
// unit's serial multiply, rounding step and division before its result strobe.
// Throughput: one transaction at a time; busy is high until the result strobe.
// Reset (synchronous, active low) empties the table; the receiver cannot stall (o_done).
// ----------------------------------------------------------------------------
// Piecewise linear line/time interpolator
// Breakpoint table with binary search and serial interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "piecewise_line_time_interpolator_assert.svh"
module piecewise_line_time_interpolator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  plti_pkg::t_op                       i_op,
    input  logic [plti_pkg::LV_W-1:0]           i_line_value,
    input  logic [plti_pkg::TIME_W-1:0]         i_time_value,
    input  logic signed [plti_pkg::FL_W-1:0]    i_frame_line,
    input  logic signed [plti_pkg::SMP_W-1:0]   i_sample_in,
    output logic                                o_done,
    output plti_pkg::t_status                   o_status,
    output logic signed [plti_pkg::LOUT_W-1:0]  o_line_out,
    output logic [plti_pkg::TIME_W-1:0]         o_time_out,
    output logic signed [plti_pkg::FL_W-1:0]    o_frame_line_out,
    output logic signed [plti_pkg::SMP_W-1:0]   o_sample_out
);
    import plti_pkg::*;

    localparam int ENT_W = BLINE_W + TIME_W;
    localparam logic [LOUT_W-1:0] HALF_LINE = LOUT_W'(1 << (LINE_FRAC_BITS - 1));

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LDCHK = 4'd1;
    localparam logic [3:0] S_FIRST = 4'd2;
    localparam logic [3:0] S_LAST  = 4'd3;
    localparam logic [3:0] S_SRCH  = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_PREV  = 4'd6;
    localparam logic [3:0] S_CUR   = 4'd7;
    localparam logic [3:0] S_MD    = 4'd8;

    logic [ENT_W-1:0]        r_mem [TABLE_DEPTH];
    logic [ENT_W-1:0]        r_rdata;
    logic [3:0]              r_state;
    logic [CNT_W-1:0]        r_cnt;
    t_op                     r_op;
    logic [LV_W-1:0]         r_lv;
    logic [TIME_W-1:0]       r_tv;
    logic signed [FL_W-1:0]  r_fl;
    logic signed [SMP_W-1:0] r_smp;
    logic [ADDR_W-1:0]       r_lo, r_hi;
    logic [BLINE_W-1:0]      r_l0;
    logic [TIME_W-1:0]       r_t0;
    logic                    r_done;
    t_status                 r_status;
    logic [LOUT_W-1:0]       r_lout;
    logic [TIME_W-1:0]       r_tout;
    logic [FL_W-1:0]         r_fout;
    logic [SMP_W-1:0]        r_sout;

    logic [ADDR_W-1:0]       n_rd_addr;
    logic                    n_wr;
    logic [ADDR_W-1:0]       mid;
    logic [BLINE_W-1:0]      rd_line;
    logic [TIME_W-1:0]       rd_time;
    logic [BLINE_W-1:0]      ld_line;
    logic [BLINE_W:0]        line_key;
    logic                    md_start, md_done;
    logic [TIME_W-1:0]       md_a, md_b, md_d;
    logic [PROD_W-1:0]       md_q;
    logic [TIME_W-1:0]       dt;
    logic [BLINE_W-1:0]      dl_int;
    logic [LOUT_W-1:0]       l0f;
    logic signed [31:0]      lsum;
    logic [TIME_W:0]         tsum;

    assign rd_line = r_rdata[ENT_W-1:TIME_W];
    assign rd_time = r_rdata[TIME_W-1:0];
    assign ld_line = r_lv[LINE_FRAC_BITS +: BLINE_W];
    assign mid     = ADDR_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    // Rounded line for a line query.
    assign line_key = (BLINE_W + 1)'((LOUT_W'(r_lv) + HALF_LINE) >> LINE_FRAC_BITS);
    assign l0f      = LOUT_W'({r_l0, LINE_FRAC_BITS'(0)});
    assign dt       = rd_time - r_t0;
    assign dl_int   = rd_line - r_l0;

    // Read address for the next table access.
    always_comb begin
        unique case (r_state)
            S_IDLE:  n_rd_addr = (start && i_op == OP_LOAD) ?
                                 ADDR_W'(r_cnt - CNT_W'(1)) : '0;
            S_FIRST: n_rd_addr = ADDR_W'(r_cnt - CNT_W'(1));
            S_SRCH:  n_rd_addr = (r_lo == r_hi) ? r_lo - ADDR_W'(1) : mid;
            S_PREV:  n_rd_addr = r_lo;
            default: n_rd_addr = '0;
        endcase
    end

    // Write enable for a breakpoint load.
    always_comb begin
        n_wr = 1'b0;
        if (r_state == S_IDLE && start && i_op == OP_LOAD && r_cnt == '0) begin
            n_wr = 1'b1;
        end else if (r_state == S_LDCHK && ld_line > rd_line && r_tv > rd_time) begin
            n_wr = 1'b1;
        end
    end

    // Breakpoint memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= (r_state == S_IDLE) ?
                {i_line_value[LINE_FRAC_BITS +: BLINE_W], i_time_value} :
                {ld_line, r_tv};
        end
        r_rdata <= r_mem[n_rd_addr];
    end

    // Operands for the shared multiply-divide unit.
    always_comb begin
        md_start = (r_state == S_CUR);
        if (r_op == OP_T2L) begin
            md_a = r_tv - r_t0;
            md_b = TIME_W'({dl_int, LINE_FRAC_BITS'(0)});
            md_d = dt;
        end else begin
            md_a = (LOUT_W'(r_lv) > l0f) ? TIME_W'(LOUT_W'(r_lv) - l0f) : '0;
            md_b = dt;
            md_d = TIME_W'({dl_int, LINE_FRAC_BITS'(0)});
        end
    end

    plti_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_a     (md_a),
        .i_b     (md_b),
        .i_d     (md_d),
        .o_done  (md_done),
        .o_quot  (md_q)
    );

    // Final sums for both query kinds.
    assign lsum = 32'(signed'({1'b0, l0f})) + 32'(signed'({1'b0, md_q[28:0]}))
                + 32'(r_fl);
    assign tsum = {1'b0, r_t0} + {1'b0, md_q[TIME_W-1:0]};

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op     <= i_op;
                        r_lv     <= i_line_value;
                        r_tv     <= i_time_value;
                        r_fl     <= i_frame_line;
                        r_smp    <= i_sample_in;
                        r_status <= ST_OK;
                        r_lout   <= '0;
                        r_tout   <= '0;
                        r_fout   <= '0;
                        r_sout   <= '0;
                        unique case (i_op)
                            OP_LOAD: begin
                                if (r_cnt == CNT_W'(TABLE_DEPTH)) begin
                                    r_status <= ST_ORDER;
                                    r_done   <= 1'b1;
                                end else if (r_cnt == '0) begin
                                    r_cnt  <= CNT_W'(1);
                                    r_done <= 1'b1;
                                end else begin
                                    r_state <= S_LDCHK;
                                end
                            end
                            OP_CLEAR: begin
                                r_cnt  <= '0;
                                r_done <= 1'b1;
                            end
                            default: begin
                                if (r_cnt < CNT_W'(2)) begin
                                    r_status <= ST_SHORT;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_FIRST;
                                end
                            end
                        endcase
                    end
                end
                S_LDCHK: begin
                    if (n_wr) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end else begin
                        r_status <= ST_ORDER;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_FIRST: begin
                    r_l0    <= rd_line;
                    r_t0    <= rd_time;
                    r_state <= S_LAST;
                end
                S_LAST: begin
                    r_lo <= ADDR_W'(1);
                    r_hi <= ADDR_W'(r_cnt - CNT_W'(1));
                    if ((r_op == OP_T2L && (r_tv < r_t0 || r_tv > rd_time)) ||
                        (r_op == OP_L2T && (LOUT_W'(r_lv) < l0f ||
                         LOUT_W'(r_lv) >= LOUT_W'({rd_line, LINE_FRAC_BITS'(0)})
                         + HALF_LINE))) begin
                        r_status <= ST_RANGE;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    r_state <= (r_lo == r_hi) ? S_PREV : S_CMP;
                end
                S_CMP: begin
                    if ((r_op == OP_T2L && rd_time < r_tv) ||
                        (r_op == OP_L2T && {1'b0, rd_line} < line_key)) begin
                        r_lo <= mid + ADDR_W'(1);
                    end else begin
                        r_hi <= mid;
                    end
                    r_state <= S_SRCH;
                end
                S_PREV: begin
                    r_l0    <= rd_line;
                    r_t0    <= rd_time;
                    r_state <= S_CUR;
                end
                S_CUR: begin
                    r_state <= S_MD;
                end
                S_MD: begin
                    if (md_done) begin
                        r_sout <= r_smp;
                        if (r_op == OP_T2L) begin
                            r_fout <= r_fl;
                            if (lsum > 32'sd268435455) begin
                                r_lout <= LOUT_W'(268435455);
                            end else if (lsum < -32'sd268435456) begin
                                r_lout <= LOUT_W'(-268435456);
                            end else begin
                                r_lout <= lsum[LOUT_W-1:0];
                            end
                        end else begin
                            if (md_q[PROD_W-1:TIME_W] != '0 || tsum[TIME_W]) begin
                                r_tout <= '1;
                            end else begin
                                r_tout <= tsum[TIME_W-1:0];
                            end
                        end
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_line_out       = r_lout;
    assign o_time_out       = r_tout;
    assign o_frame_line_out = r_fout;
    assign o_sample_out     = r_sout;

    // Checks on the sequencer and table state.
    `PLTI_ASSERT_NOW(a_done_idle, r_done, r_state == S_IDLE)
    `PLTI_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(TABLE_DEPTH))
    `PLTI_ASSERT_NEXT(a_accept_progress, start && !busy, r_done || busy)
    `PLTI_ASSERT_NOW(a_err_zero, r_done && r_status != ST_OK, r_sout == '0 && r_lout == '0)
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line/time interpolator testbench
// Drives breakpoint loads, clears and both query kinds through the start/busy
// handshake, predicts results with an independent model of the table or a directed
// status, and checks each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import plti_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 140;
    localparam logic [63:0] TIME_MAX = 64'hFF_FFFF_FFFF;

    typedef struct packed {
        t_status                    status;
        logic signed [LOUT_W-1:0]   line_out;
        logic [TIME_W-1:0]          time_out;
        logic signed [FL_W-1:0]     frame_out;
        logic signed [SMP_W-1:0]    sample_out;
    } interp_res_t;

    typedef struct packed {
        t_op                        op;
        logic [LV_W-1:0]            line_val;
        logic [TIME_W-1:0]          time_val;
        logic signed [FL_W-1:0]     frame;
        logic signed [SMP_W-1:0]    sample;
        bit                         typed;
        t_status                    typed_status;
    } stim_row_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    t_op                        i_op;
    logic [LV_W-1:0]            i_line_value;
    logic [TIME_W-1:0]          i_time_value;
    logic signed [FL_W-1:0]     i_frame_line;
    logic signed [SMP_W-1:0]    i_sample_in;
    logic                       o_done;
    t_status                    o_status;
    logic signed [LOUT_W-1:0]   o_line_out;
    logic [TIME_W-1:0]          o_time_out;
    logic signed [FL_W-1:0]     o_frame_line_out;
    logic signed [SMP_W-1:0]    o_sample_out;

    // Predictor copy of the breakpoint table.
    logic [BLINE_W-1:0]         bp_lines [TABLE_DEPTH];
    logic [TIME_W-1:0]          bp_times [TABLE_DEPTH];
    int                         bp_count = 0;

    interp_res_t                pending_results [$];
    int                         mismatches = 0;
    int                         idle_pct = 0;
    int                         stall_cycles = 0;
    int                         items_sent = 0;
    stim_row_t                  directed_rows [22];

    always #5 i_clk = ~i_clk;

    piecewise_line_time_interpolator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_line_value     (i_line_value),
        .i_time_value     (i_time_value),
        .i_frame_line     (i_frame_line),
        .i_sample_in      (i_sample_in),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_line_out       (o_line_out),
        .o_time_out       (o_time_out),
        .o_frame_line_out (o_frame_line_out),
        .o_sample_out     (o_sample_out)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // round(a * b / d) with ties rounded up, carried out at full width.
    function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
                                                    logic [63:0] d);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod + (d >> 1);
        return 64'(prod / d);
    endfunction

    // Works out the result of one transaction and updates the table copy.
    function automatic interp_res_t interpolate(t_op op, logic [LV_W-1:0] lv,
                                                logic [TIME_W-1:0] tv,
                                                logic signed [FL_W-1:0] fl,
                                                logic signed [SMP_W-1:0] smp);
        interp_res_t        res;
        logic [BLINE_W-1:0] ln;
        logic [63:0]        base, span, dl, q, t, lim, rline;
        longint             v;
        int                 i;
        res = '0;
        ln = lv[LV_W-1:LINE_FRAC_BITS];
        if (op == OP_LOAD) begin
            if (bp_count >= TABLE_DEPTH) begin
                res.status = ST_ORDER;
            end else if (bp_count > 0 && (ln <= bp_lines[bp_count-1] ||
                                          tv <= bp_times[bp_count-1])) begin
                res.status = ST_ORDER;
            end else begin
                bp_lines[bp_count] = ln;
                bp_times[bp_count] = tv;
                bp_count++;
            end
        end else if (op == OP_CLEAR) begin
            bp_count = 0;
        end else if (bp_count < 2) begin
            res.status = ST_SHORT;
        end else if (op == OP_T2L) begin
            if (tv < bp_times[0] || tv > bp_times[bp_count-1]) begin
                res.status = ST_RANGE;
            end else begin
                for (i = 1; i < bp_count - 1 && bp_times[i] < tv; i++) ;
                base = 64'(bp_times[i-1]);
                span = 64'(bp_times[i]) - base;
                dl = 64'(bp_lines[i] - bp_lines[i-1]) << LINE_FRAC_BITS;
                q = scaled_quotient(64'(tv) - base, dl, span);
                v = longint'(64'(bp_lines[i-1]) << LINE_FRAC_BITS) + longint'(q)
                    + longint'(fl);
                if (v > 268435455) v = 268435455;
                if (v < -268435456) v = -268435456;
                res.line_out   = LOUT_W'(v);
                res.frame_out  = fl;
                res.sample_out = smp;
            end
        end else begin
            base = 64'(bp_lines[0]) << LINE_FRAC_BITS;
            lim = (64'(bp_lines[bp_count-1]) * 2 + 1) << LINE_FRAC_BITS;
            if (64'(lv) < base || 64'(lv) * 2 >= lim) begin
                res.status = ST_RANGE;
            end else begin
                rline = (64'(lv) * 2 + (64'd1 << LINE_FRAC_BITS)) >> (LINE_FRAC_BITS + 1);
                for (i = 1; i < bp_count - 1 && 64'(bp_lines[i]) < rline; i++) ;
                base = 64'(bp_lines[i-1]) << LINE_FRAC_BITS;
                span = 64'(bp_times[i] - bp_times[i-1]);
                dl = 64'(bp_lines[i] - bp_lines[i-1]) << LINE_FRAC_BITS;
                q = (64'(lv) > base) ? scaled_quotient(64'(lv) - base, span, dl) : 64'd0;
                t = 64'(bp_times[i-1]) + q;
                if (q > TIME_MAX || t > TIME_MAX) t = TIME_MAX;
                res.time_out   = TIME_W'(t);
                res.sample_out = smp;
            end
        end
        return res;
    endfunction

    // Presents one transaction and holds it until the block takes it.
    task automatic send(t_op op, logic [LV_W-1:0] lv, logic [TIME_W-1:0] tv,
                        logic signed [FL_W-1:0] fl, logic signed [SMP_W-1:0] smp,
                        bit typed = 1'b0, t_status typed_status = ST_OK);
        interp_res_t res;
        start        <= 1'b1;
        i_op         <= op;
        i_line_value <= lv;
        i_time_value <= tv;
        i_frame_line <= fl;
        i_sample_in  <= smp;
        do @(posedge i_clk); while (busy);
        items_sent++;
        res = interpolate(op, lv, tv, fl, smp);
        if (typed) begin
            res = '0;
            res.status = typed_status;
        end
        pending_results.insert(pending_results.size(), res);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random query that mostly lands inside the current span.
    task automatic send_query();
        t_op             op;
        int              j;
        logic [63:0]     lo, hi, val;
        op = $urandom_range(1) ? OP_T2L : OP_L2T;
        if (bp_count < 2) begin
            send(op, LV_W'($urandom), TIME_W'(rand64()), FL_W'($urandom), SMP_W'($urandom));
            return;
        end
        j = $urandom_range(bp_count - 2);
        if (op == OP_T2L) begin
            lo = bp_times[j];
            hi = bp_times[j+1];
            val = lo + rand64() % (hi - lo + 1);
            if ($urandom_range(7) == 0) val = 64'(bp_times[0]) - $urandom_range(3);
            if ($urandom_range(7) == 0) val = 64'(bp_times[bp_count-1]) + $urandom_range(3);
        end else begin
            lo = 64'(bp_lines[j]) << LINE_FRAC_BITS;
            hi = (64'(bp_lines[j+1]) << LINE_FRAC_BITS) + 128;
            val = lo + rand64() % (hi - lo);
            if ($urandom_range(7) == 0) val = lo - $urandom_range(2);
            if ($urandom_range(7) == 0)
                val = (64'(bp_lines[bp_count-1]) << LINE_FRAC_BITS) + 126 + $urandom_range(3);
        end
        send(op, LV_W'(val), TIME_W'(val), FL_W'($urandom), SMP_W'($urandom));
    endtask

    // Clear, load an increasing table, then query it.
    task automatic table_session(int loads, int queries, int line_step, int time_bits);
        logic [63:0] ln, tm;
        int          k;
        send(OP_CLEAR, LV_W'($urandom), TIME_W'(rand64()), FL_W'($urandom), SMP_W'($urandom));
        ln = $urandom_range(2000);
        tm = rand64() >> (64 - time_bits + 2);
        for (k = 0; k < loads; k++) begin
            send(OP_LOAD, LV_W'({ln[19:0], 8'($urandom)}), TIME_W'(tm),
                 FL_W'($urandom), SMP_W'($urandom));
            ln = ln + $urandom_range(1, line_step);
            tm = tm + 1 + (rand64() >> (64 - time_bits));
            if ($urandom_range(19) == 0) begin
                ln = ln - $urandom_range(1, 2);
            end
        end
        for (k = 0; k < queries; k++) send_query();
    endtask

    task automatic random_phase(int pct, int items);
        int first_item;
        idle_pct = pct;
        first_item = items_sent;
        while (items_sent - first_item < items) begin
            if ($urandom_range(4) == 0) begin
                send(t_op'($urandom_range(3)), LV_W'($urandom), TIME_W'(rand64()),
                     FL_W'($urandom), SMP_W'($urandom));
            end else begin
                case ($urandom_range(2))
                    0: table_session($urandom_range(0, 4), $urandom_range(3, 12), 4, 6);
                    1: table_session($urandom_range(2, 12), $urandom_range(3, 15), 1000, 24);
                    default: table_session($urandom_range(2, 12), $urandom_range(3, 15),
                                           60000, 38);
                endcase
            end
        end
    endtask

    // Result checker: the receiver cannot stall, so every strobe is taken.
    always @(posedge i_clk) begin
        interp_res_t exp_res;
        interp_res_t got_res;
        if (i_rst_n && o_done) begin
            got_res = '{o_status, o_line_out, o_time_out, o_frame_line_out, o_sample_out};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transaction: %p", got_res);
            end else begin
                exp_res = pending_results.pop_front();
                if (got_res !== exp_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: expected %p, got %p", exp_res, got_res);
                end
            end
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles > WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        start        = 1'b0;
        i_rst_n      = 1'b0;
        i_op         = OP_LOAD;
        i_line_value = '0;
        i_time_value = '0;
        i_frame_line = '0;
        i_sample_in  = '0;
        directed_rows = '{
            '{OP_T2L,   28'd0,          40'd500,        24'sd0, 28'sd5, 1'b1, ST_SHORT},
            '{OP_L2T,   28'd2560,       40'd0,          24'sd0, 28'sd5, 1'b1, ST_SHORT},
            '{OP_LOAD,  28'd2560,       40'd1000,       24'sd0, 28'sd0, 1'b1, ST_OK},
            '{OP_T2L,   28'd0,          40'd1000,       24'sd0, 28'sd1, 1'b1, ST_SHORT},
            '{OP_LOAD,  28'd2600,       40'd2000,       24'sd0, 28'sd0, 1'b1, ST_ORDER},
            '{OP_LOAD,  28'd5120,       40'd1000,       24'sd0, 28'sd0, 1'b1, ST_ORDER},
            '{OP_LOAD,  28'd5120,       40'd3000,       24'sd0, 28'sd0, 1'b1, ST_OK},
            '{OP_LOAD,  28'hFFF_FFFF,   40'hFF_FFFF_FFFF, 24'sd0, 28'sd0, 1'b1, ST_OK},
            '{OP_T2L,   28'd0,          40'd999,        24'sd3, 28'sd7, 1'b1, ST_RANGE},
            '{OP_T2L,   28'd0,          40'd1000,       -24'sd8388608, 28'sd134217727,
              1'b0, ST_OK},
            '{OP_T2L,   28'd0,          40'hFF_FFFF_FFFF, 24'sd8388607, -28'sd134217728,
              1'b0, ST_OK},
            '{OP_T2L,   28'd0,          40'd2000,       24'sd256, 28'sd9, 1'b0, ST_OK},
            '{OP_L2T,   28'd2559,       40'd0,          24'sd0, 28'sd9, 1'b1, ST_RANGE},
            '{OP_L2T,   28'd2560,       40'd0,          24'sd0, 28'sd9, 1'b0, ST_OK},
            '{OP_L2T,   28'hFFF_FFFF,   40'd0,          24'sd0, 28'sd9, 1'b1, ST_RANGE},
            '{OP_CLEAR, 28'd0,          40'd0,          24'sd0, 28'sd0, 1'b1, ST_OK},
            '{OP_L2T,   28'd2560,       40'd0,          24'sd0, 28'sd2, 1'b1, ST_SHORT},
            '{OP_LOAD,  28'd0,          40'd0,          24'sd0, 28'sd0, 1'b1, ST_OK},
            '{OP_LOAD,  28'd256,        40'hFF_FFFF_FFFF, 24'sd0, 28'sd0, 1'b1, ST_OK},
            '{OP_L2T,   28'd383,        40'd0,          24'sd0, 28'sd4, 1'b0, ST_OK},
            '{OP_L2T,   28'd128,        40'd0,          24'sd0, 28'sd4, 1'b0, ST_OK},
            '{OP_T2L,   28'd0,          40'd0,          24'sd0, 28'sd4, 1'b0, ST_OK}
        };

        // Synchronous reset held low before release.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, back to back.
        foreach (directed_rows[r]) begin
            send(directed_rows[r].op, directed_rows[r].line_val, directed_rows[r].time_val,
                 directed_rows[r].frame, directed_rows[r].sample,
                 directed_rows[r].typed, directed_rows[r].typed_status);
        end

        // Random traffic with the sender idling at different rates.
        random_phase(27, PHASE_ITEMS);
        drain();
        random_phase(67, PHASE_ITEMS);
        drain();
        idle_pct = 0;
        // Fill the table to its depth, overflow it, then query the deep table.
        table_session(TABLE_DEPTH + 2, 40, 1000, 28);
        random_phase(0, PHASE_ITEMS);

        drain();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/plti_pkg.sv
rtl/core/plti_muldiv.sv
rtl/core/piecewise_line_time_interpolator.sv
tb/sv/tb_top.sv
